/* rtl/core/segment_tree_min_max_xor_macros.svh */
// Assertion macros for the segment tree block.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef SEGMENT_TREE_MIN_MAX_XOR_MACROS_SVH
`define SEGMENT_TREE_MIN_MAX_XOR_MACROS_SVH

`ifndef ASSERT_OFF
// Check cons in the same cycle as ante.
`define STMMX_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Check cons in the cycle after ante.
`define STMMX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define STMMX_ASSERT_SAME(lbl, ante, cons, msg)
`define STMMX_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* rtl/core/stmmx_pkg.sv */
package stmmx_pkg;

  localparam int LEAVES  = 1024;
  localparam int DATA_W  = 32;
  localparam int NODES   = 2 * LEAVES;
  localparam int NODE_AW = $clog2(NODES);
  localparam int IDX_W   = $clog2(LEAVES);
  localparam int CNT_W   = IDX_W + 1;
  localparam int POS_W   = NODE_AW + 1;
  localparam int NODE_W  = 3 * DATA_W;

  localparam logic [CNT_W-1:0] LEAVES_C = CNT_W'(LEAVES);

  // Identities of the three combines
  localparam logic signed [DATA_W-1:0] MIN_ID = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] MAX_ID = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic {
    REQ_UPDATE = 1'b0,
    REQ_QUERY  = 1'b1
  } req_type_t;

  localparam logic STAT_OK      = 1'b0;
  localparam logic STAT_BAD_IDX = 1'b1;

  typedef struct packed {
    req_type_t                  req_type;
    logic [IDX_W-1:0]           leaf_index;
    logic signed [DATA_W-1:0]   leaf_min;
    logic signed [DATA_W-1:0]   leaf_max;
    logic [DATA_W-1:0]          leaf_xor;
    logic [CNT_W-1:0]           range_lo;
    logic [CNT_W-1:0]           range_hi;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] res_min;
    logic signed [DATA_W-1:0] res_max;
    logic [DATA_W-1:0]        res_xor;
    logic                     status;
  } out_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] nmin;
    logic signed [DATA_W-1:0] nmax;
    logic [DATA_W-1:0]        nxor;
  } node_t;

  localparam node_t NODE_ID = '{nmin: MIN_ID, nmax: MAX_ID, nxor: '0};

  typedef struct packed {
    logic               we;
    logic [NODE_AW-1:0] waddr;
    node_t              wdata;
    logic [NODE_AW-1:0] raddr;
  } mem_req_t;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_DEC,
    ST_UPD_LVL,
    ST_QRY,
    ST_OUT
  } state_t;

endpackage

/* rtl/core/stmmx_ram.sv */
module stmmx_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/stmmx_comb.sv */
module stmmx_comb (
  input  stmmx_pkg::node_t a,
  input  stmmx_pkg::node_t b,
  output stmmx_pkg::node_t y
);

  // Merge two nodes: signed min, signed max, xor
  always_comb begin
    y.nmin = (b.nmin < a.nmin) ? b.nmin : a.nmin;
    y.nmax = (a.nmax < b.nmax) ? b.nmax : a.nmax;
    y.nxor = a.nxor ^ b.nxor;
  end

endmodule

/* rtl/core/stmmx_seq.sv */
module stmmx_seq (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  stmmx_pkg::in_t                 in_item,
  input  logic                           cfg_valid,
  input  logic [stmmx_pkg::CNT_W-1:0]    cfg_data,
  output logic                           busy,
  output logic                           out_valid,
  output stmmx_pkg::out_t                out_item,
  output stmmx_pkg::mem_req_t            mreq,
  input  stmmx_pkg::node_t               rdata,
  output stmmx_pkg::node_t               comb_a,
  input  stmmx_pkg::node_t               comb_y
);

  stmmx_pkg::state_t                 state_r, state_nxt;
  logic [stmmx_pkg::NODE_AW-1:0]     clr_cnt_r, clr_cnt_nxt;
  logic [stmmx_pkg::CNT_W-1:0]       n_used_r;
  stmmx_pkg::in_t                    req_r, req_nxt;
  logic [stmmx_pkg::NODE_AW-1:0]     k_r, k_nxt;
  logic [stmmx_pkg::POS_W-1:0]       l_r, l_nxt, r_r, r_nxt;
  logic                              pend_r, pend_nxt;
  stmmx_pkg::node_t                  acc_r, acc_nxt;
  logic                              stat_r, stat_nxt;
  logic                              out_valid_r, out_valid_nxt;
  stmmx_pkg::out_t                   out_r, out_nxt;

  logic [stmmx_pkg::CNT_W-1:0]       n_eff;
  logic [stmmx_pkg::CNT_W-1:0]       hi_c;
  logic                              idx_ok;
  logic                              q_nonempty;
  logic [stmmx_pkg::NODE_AW-1:0]     leaf_k;
  logic [stmmx_pkg::NODE_AW-1:0]     parent_k;
  logic                              l_lt_r;
  logic [stmmx_pkg::POS_W-1:0]       l_inc;
  logic [stmmx_pkg::POS_W-1:0]       r_dec;
  stmmx_pkg::node_t                  leaf_val;

  // Decode the latched item against the leaf count in use
  always_comb begin
    n_eff      = (n_used_r > stmmx_pkg::LEAVES_C) ? stmmx_pkg::LEAVES_C : n_used_r;
    idx_ok     = {1'b0, req_r.leaf_index} < n_eff;
    hi_c       = (req_r.range_hi > n_eff) ? n_eff : req_r.range_hi;
    q_nonempty = req_r.range_lo < hi_c;
    leaf_k     = {1'b1, req_r.leaf_index};
    parent_k   = k_r >> 1;
    l_lt_r     = l_r < r_r;
    l_inc      = l_r + stmmx_pkg::POS_W'(1);
    r_dec      = r_r - stmmx_pkg::POS_W'(1);
    leaf_val   = '{nmin: req_r.leaf_min, nmax: req_r.leaf_max, nxor: req_r.leaf_xor};
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      stmmx_pkg::ST_CLR: begin
        if (clr_cnt_r == '1) state_nxt = stmmx_pkg::ST_IDLE;
      end
      stmmx_pkg::ST_IDLE: begin
        if (start) state_nxt = stmmx_pkg::ST_DEC;
      end
      stmmx_pkg::ST_DEC: begin
        if (req_r.req_type == stmmx_pkg::REQ_UPDATE) begin
          state_nxt = idx_ok ? stmmx_pkg::ST_UPD_LVL : stmmx_pkg::ST_OUT;
        end else begin
          state_nxt = q_nonempty ? stmmx_pkg::ST_QRY : stmmx_pkg::ST_OUT;
        end
      end
      stmmx_pkg::ST_UPD_LVL: begin
        if (parent_k == stmmx_pkg::NODE_AW'(1)) state_nxt = stmmx_pkg::ST_OUT;
      end
      stmmx_pkg::ST_QRY: begin
        if (!l_lt_r && !pend_r) state_nxt = stmmx_pkg::ST_OUT;
      end
      stmmx_pkg::ST_OUT: begin
        state_nxt = stmmx_pkg::ST_IDLE;
      end
      default: state_nxt = stmmx_pkg::ST_IDLE;
    endcase
  end

  // Datapath control and memory requests
  always_comb begin
    mreq.we       = 1'b0;
    mreq.waddr    = clr_cnt_r;
    mreq.wdata    = stmmx_pkg::NODE_ID;
    mreq.raddr    = '0;
    clr_cnt_nxt   = clr_cnt_r;
    req_nxt       = req_r;
    k_nxt         = k_r;
    l_nxt         = l_r;
    r_nxt         = r_r;
    pend_nxt      = 1'b0;
    acc_nxt       = acc_r;
    stat_nxt      = stat_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    unique case (state_r)
      stmmx_pkg::ST_CLR: begin
        // sweep identities through the store
        mreq.we     = 1'b1;
        clr_cnt_nxt = clr_cnt_r + stmmx_pkg::NODE_AW'(1);
      end
      stmmx_pkg::ST_IDLE: begin
        if (start) req_nxt = in_item;
      end
      stmmx_pkg::ST_DEC: begin
        stat_nxt = stmmx_pkg::STAT_OK;
        acc_nxt  = stmmx_pkg::NODE_ID;
        if (req_r.req_type == stmmx_pkg::REQ_UPDATE) begin
          if (idx_ok) begin
            // write the leaf, fetch its sibling
            mreq.we    = 1'b1;
            mreq.waddr = leaf_k;
            mreq.wdata = leaf_val;
            mreq.raddr = leaf_k ^ stmmx_pkg::NODE_AW'(1);
            acc_nxt    = leaf_val;
            k_nxt      = leaf_k;
          end else begin
            stat_nxt = stmmx_pkg::STAT_BAD_IDX;
          end
        end else begin
          l_nxt = stmmx_pkg::POS_W'(req_r.range_lo) + stmmx_pkg::POS_W'(stmmx_pkg::LEAVES);
          r_nxt = stmmx_pkg::POS_W'(hi_c) + stmmx_pkg::POS_W'(stmmx_pkg::LEAVES);
        end
      end
      stmmx_pkg::ST_UPD_LVL: begin
        // merge with sibling, write parent, fetch parent's sibling
        mreq.we    = 1'b1;
        mreq.waddr = parent_k;
        mreq.wdata = comb_y;
        mreq.raddr = parent_k ^ stmmx_pkg::NODE_AW'(1);
        acc_nxt    = comb_y;
        k_nxt      = parent_k;
      end
      stmmx_pkg::ST_QRY: begin
        // fold the node read last cycle
        if (pend_r) acc_nxt = comb_y;
        if (l_lt_r) begin
          if (l_r[0]) begin
            mreq.raddr = l_r[stmmx_pkg::NODE_AW-1:0];
            pend_nxt   = 1'b1;
            if (r_r[0]) begin
              l_nxt = l_inc;
            end else begin
              l_nxt = l_inc >> 1;
              r_nxt = r_r >> 1;
            end
          end else if (r_r[0]) begin
            mreq.raddr = r_dec[stmmx_pkg::NODE_AW-1:0];
            pend_nxt   = 1'b1;
            l_nxt      = l_r >> 1;
            r_nxt      = r_dec >> 1;
          end else begin
            l_nxt = l_r >> 1;
            r_nxt = r_r >> 1;
          end
        end
      end
      stmmx_pkg::ST_OUT: begin
        out_valid_nxt = 1'b1;
        if (req_r.req_type == stmmx_pkg::REQ_QUERY) begin
          out_nxt = '{res_min: acc_r.nmin, res_max: acc_r.nmax, res_xor: acc_r.nxor,
                      status: stmmx_pkg::STAT_OK};
        end else begin
          out_nxt = '{res_min: '0, res_max: '0, res_xor: '0, status: stat_r};
        end
      end
      default: begin
        mreq.we = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= stmmx_pkg::ST_CLR;
      clr_cnt_r   <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      n_used_r    <= stmmx_pkg::LEAVES_C;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) n_used_r <= cfg_data;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    req_r  <= req_nxt;
    k_r    <= k_nxt;
    l_r    <= l_nxt;
    r_r    <= r_nxt;
    acc_r  <= acc_nxt;
    stat_r <= stat_nxt;
    out_r  <= out_nxt;
  end

  assign busy      = (state_r != stmmx_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;
  assign comb_a    = acc_r;

endmodule

/* rtl/core/segment_tree_min_max_xor.sv */
// Segment tree over 1024 leaf positions; each node keeps a min, a max and an xor.
// Input: an item is taken when start is high and busy is low. An update item
// (req_type 0) writes one leaf and recombines its ancestors; a query item
// (req_type 1) returns min, max and xor over [range_lo, range_hi).
// Output: one result per item, on out_item for exactly one cycle while
// out_valid is high. The receiver cannot stall, so the result must be taken then.
// Configuration: cfg_data carries n_used, written when cfg_valid and cfg_ready
// are high; cfg_ready is always high. Write it only while the block is idle.
// Sequencing: an accepted update makes one node write per tree level through the
// single-port-pair node store and the shared merge unit; a rejected update or an
// empty query touches no node, and any other query makes at most two node reads
// per level.
// busy stays high until the result cycle, so items do not overlap.
// Reset: synchronous, active low. After reset a clearing pass writes identities
// into all 2048 nodes, one per cycle; busy is high throughout the pass.
`include "segment_tree_min_max_xor_macros.svh"

module segment_tree_min_max_xor (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  stmmx_pkg::in_t              in_item,
  output logic                        out_valid,
  output stmmx_pkg::out_t             out_item,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [stmmx_pkg::CNT_W-1:0] cfg_data
);

  stmmx_pkg::mem_req_t mreq;
  stmmx_pkg::node_t    rdata;
  stmmx_pkg::node_t    comb_a;
  stmmx_pkg::node_t    comb_y;

  assign cfg_ready = 1'b1;

  // Sequencer
  stmmx_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_item   (in_item),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .busy      (busy),
    .out_valid (out_valid),
    .out_item  (out_item),
    .mreq      (mreq),
    .rdata     (rdata),
    .comb_a    (comb_a),
    .comb_y    (comb_y)
  );

  // Node store
  stmmx_ram #(
    .WIDTH (stmmx_pkg::NODE_W),
    .DEPTH (stmmx_pkg::NODES)
  ) u_ram (
    .clk   (clk),
    .we    (mreq.we),
    .waddr (mreq.waddr),
    .wdata (mreq.wdata),
    .raddr (mreq.raddr),
    .rdata (rdata)
  );

  // Shared merge unit
  stmmx_comb u_comb (
    .a (comb_a),
    .b (rdata),
    .y (comb_y)
  );

  // Checks
  `STMMX_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
  `STMMX_ASSERT_NEXT(a_strobe_once, out_valid, !out_valid, "result strobe longer than a cycle")
  `STMMX_ASSERT_SAME(a_result_idle, out_valid, !busy, "result shown while busy")
  `STMMX_ASSERT_SAME(a_status_upd, out_valid && out_item.status, out_item.res_xor == '0,
                     "rejected update carries data")

endmodule

/* verif/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import stmmx_pkg::*;

  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int MAX_REPORTS   = 40;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             start     = 1'b0;
  logic             busy;
  in_t              in_item   = '0;
  logic             out_valid;
  out_t             out_item;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CNT_W-1:0] cfg_data  = '0;

  // Leaf values as the tree should hold them, and the leaf count in force
  logic [CNT_W-1:0]         leaf_count;
  logic signed [DATA_W-1:0] leaf_min_mem [LEAVES];
  logic signed [DATA_W-1:0] leaf_max_mem [LEAVES];
  logic [DATA_W-1:0]        leaf_xor_mem [LEAVES];

  out_t pending_results[$];

  int errors        = 0;
  int reports       = 0;
  int cycles        = 0;
  int n_writes      = 0;
  int n_rejected    = 0;
  int n_queries     = 0;
  int n_nonempty    = 0;
  int n_cfg_writes  = 0;
  int pending_gap   = 0;
  bit calm          = 1'b0;

  segment_tree_min_max_xor u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Leaf count as the tree sees it: anything above the leaf total acts as the total
  function automatic logic [CNT_W-1:0] live_leaves();
    return (leaf_count > LEAVES_C) ? LEAVES_C : leaf_count;
  endfunction

  // Apply one item to the leaf store and work out the result it should give
  function automatic out_t tree_apply(in_t r);
    out_t             res;
    logic [CNT_W-1:0] n;
    logic [CNT_W-1:0] hi;
    int               p;
    n   = live_leaves();
    res = '{res_min: MIN_ID, res_max: MAX_ID, res_xor: '0, status: STAT_OK};
    if (r.req_type == REQ_UPDATE) begin
      res.res_min = '0;
      res.res_max = '0;
      if ({1'b0, r.leaf_index} >= n) begin
        res.status = STAT_BAD_IDX;
        n_rejected++;
      end else begin
        leaf_min_mem[r.leaf_index] = r.leaf_min;
        leaf_max_mem[r.leaf_index] = r.leaf_max;
        leaf_xor_mem[r.leaf_index] = r.leaf_xor;
        n_writes++;
      end
    end else begin
      n_queries++;
      hi = (r.range_hi > n) ? n : r.range_hi;
      if (r.range_lo < hi) n_nonempty++;
      for (p = int'(r.range_lo); p < int'(hi); p++) begin
        if (leaf_min_mem[p] < res.res_min) res.res_min = leaf_min_mem[p];
        if (leaf_max_mem[p] > res.res_max) res.res_max = leaf_max_mem[p];
        res.res_xor = res.res_xor ^ leaf_xor_mem[p];
      end
    end
    return res;
  endfunction

  function automatic void check_field(string name, logic [DATA_W-1:0] want,
                                      logic [DATA_W-1:0] got);
    if (got !== want) begin
      errors++;
      if (reports < MAX_REPORTS) begin
        reports++;
        $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
      end
    end
  endfunction

  // Compare every result with the oldest expectation
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (reports < MAX_REPORTS) begin
          reports++;
          $display("%0t: unexpected result: expected none, got %p", $time, out_item);
        end
      end else begin
        want = pending_results.pop_front();
        check_field("res_min", want.res_min, out_item.res_min);
        check_field("res_max", want.res_max, out_item.res_max);
        check_field("res_xor", want.res_xor, out_item.res_xor);
        check_field("status", DATA_W'(want.status), DATA_W'(out_item.status));
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding", $time, cycles,
               pending_results.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Hand one item to the block and record what it should return
  task automatic send_request(input in_t r, output logic rejected);
    out_t want;
    if (pending_gap > 0) repeat (pending_gap) @(posedge clk);
    start   <= 1'b1;
    in_item <= r;
    do @(posedge clk); while (busy);
    want = tree_apply(r);
    pending_results.push_back(want);
    rejected = (want.status == STAT_BAD_IDX);
    pending_gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
    if (pending_gap > 0) start <= 1'b0;
  endtask

  // Drop start, drain outstanding results and let the block fall idle
  task automatic settle_idle();
    if (pending_gap == 0) start <= 1'b0;
    pending_gap = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  task automatic write_leaf_count(logic [CNT_W-1:0] value);
    settle_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    leaf_count = value;
    n_cfg_writes++;
  endtask

  function automatic in_t make_update(int idx, logic [DATA_W-1:0] mn, logic [DATA_W-1:0] mx,
                                      logic [DATA_W-1:0] xr);
    in_t r;
    r.req_type   = REQ_UPDATE;
    r.leaf_index = IDX_W'(idx);
    r.leaf_min   = mn;
    r.leaf_max   = mx;
    r.leaf_xor   = xr;
    r.range_lo   = CNT_W'($urandom());
    r.range_hi   = CNT_W'($urandom());
    return r;
  endfunction

  function automatic in_t make_query(int lo, int hi);
    in_t r;
    r.req_type   = REQ_QUERY;
    r.leaf_index = IDX_W'($urandom());
    r.leaf_min   = $urandom();
    r.leaf_max   = $urandom();
    r.leaf_xor   = $urandom();
    r.range_lo   = CNT_W'(lo);
    r.range_hi   = CNT_W'(hi);
    return r;
  endfunction

  // Data word biased towards the signed extremes and all-zero / all-one
  function automatic logic [DATA_W-1:0] rand_word();
    case ($urandom_range(0, 9))
      0: return MIN_ID;
      1: return MAX_ID;
      2: return '0;
      3: return '1;
      default: return $urandom();
    endcase
  endfunction

  // Mostly in-range leaves and sensible ranges, with boundary and noise cases mixed in
  function automatic in_t rand_request();
    in_t r;
    int  n;
    int  idx;
    int  lo;
    int  hi;
    int  pick;
    n = int'(live_leaves());
    r.req_type = ($urandom_range(0, 99) < 45) ? REQ_UPDATE : REQ_QUERY;
    r.leaf_min = rand_word();
    r.leaf_max = rand_word();
    r.leaf_xor = rand_word();
    pick = $urandom_range(0, 99);
    if (pick < 70 && n > 0) begin
      idx = $urandom_range(0, n - 1);
    end else if (pick < 85) begin
      idx = n - 1 + $urandom_range(0, 2);
      if (idx < 0) idx = 0;
      if (idx > LEAVES - 1) idx = LEAVES - 1;
    end else begin
      idx = $urandom_range(0, LEAVES - 1);
    end
    r.leaf_index = IDX_W'(idx);
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      lo = $urandom_range(0, n);
      hi = $urandom_range(lo, n);
    end else if (pick < 70) begin
      lo = $urandom_range(0, n);
      hi = lo + $urandom_range(1, 4);
    end else if (pick < 85) begin
      lo = $urandom_range(0, 2047);
      hi = $urandom_range(0, 2047);
    end else begin
      lo = $urandom_range(0, LEAVES);
      hi = lo;
    end
    r.range_lo = CNT_W'(lo);
    r.range_hi = CNT_W'(hi);
    return r;
  endfunction

  task automatic send_list(input in_t items[$]);
    logic rejected;
    foreach (items[i]) send_request(items[i], rejected);
  endtask

  // Freshly cleared tree answers every query with the identities
  task automatic test_empty_tree();
    in_t items[$];
    items.push_back(make_query(0, LEAVES));
    items.push_back(make_query(0, 2047));
    items.push_back(make_query(LEAVES, 2047));
    send_list(items);
  endtask

  // Extreme data at the edge leaves, alternating bit patterns, edge ranges
  task automatic test_field_extremes();
    in_t items[$];
    items.push_back(make_update(0, MAX_ID, MIN_ID, '1));
    items.push_back(make_update(LEAVES - 1, MIN_ID, MAX_ID, '0));
    items.push_back(make_update(341, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555));
    items.push_back(make_update(682, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA));
    items.push_back(make_query(0, LEAVES));
    items.push_back(make_query(0, 1));
    items.push_back(make_query(LEAVES - 1, LEAVES));
    items.push_back(make_query(1, LEAVES - 1));
    items.push_back(make_query(5, 5));
    items.push_back(make_query(700, 3));
    items.push_back(make_query(LEAVES, LEAVES));
    send_list(items);
  endtask

  // One leaf, none, an oversized count, then back: stored leaves must survive
  task automatic test_leaf_count_limits();
    in_t items[$];
    write_leaf_count(CNT_W'(1));
    items = '{make_update(1, $urandom(), $urandom(), $urandom()),
              make_update(0, 32'sd7, -32'sd9, 32'h1234_5678),
              make_query(0, LEAVES)};
    send_list(items);
    write_leaf_count(CNT_W'(0));
    items = '{make_update(0, $urandom(), $urandom(), $urandom()), make_query(0, LEAVES)};
    send_list(items);
    write_leaf_count('1);
    items = '{make_update(LEAVES - 1, -32'sd3, 32'sd3, 32'hDEAD_BEEF),
              make_query(1000, 2047)};
    send_list(items);
    write_leaf_count(LEAVES_C);
    items = '{make_query(0, LEAVES)};
    send_list(items);
  endtask

  task automatic run_random(int target);
    int   accepted;
    logic rejected;
    accepted = 0;
    while (accepted < target) begin
      send_request(rand_request(), rejected);
      if (!rejected) accepted++;
    end
  endtask

  // Random traffic under several leaf counts; the last phase runs without gaps
  task automatic test_random_traffic();
    write_leaf_count(LEAVES_C);
    run_random(400);
    write_leaf_count(CNT_W'($urandom_range(2, LEAVES - 1)));
    run_random(250);
    write_leaf_count(CNT_W'($urandom_range(1, 8)));
    run_random(150);
    write_leaf_count('1);
    run_random(100);
    write_leaf_count(LEAVES_C);
    calm = 1'b1;
    run_random(200);
  endtask

  initial begin
    leaf_count = LEAVES_C;
    for (int i = 0; i < LEAVES; i++) begin
      leaf_min_mem[i] = MIN_ID;
      leaf_max_mem[i] = MAX_ID;
      leaf_xor_mem[i] = '0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // hold off until the clearing pass has finished
    while (busy !== 1'b0) @(posedge clk);

    test_empty_tree();
    test_field_extremes();
    test_leaf_count_limits();
    test_random_traffic();
    settle_idle();

    $display("Run covered %0d leaf writes, %0d rejected writes and %0d range queries",
             n_writes, n_rejected, n_queries);
    $display("(%0d non-empty) across %0d leaf-count settings; %0d mismatches.",
             n_nonempty, n_cfg_writes, errors);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/stmmx_pkg.sv
rtl/core/stmmx_ram.sv
rtl/core/stmmx_comb.sv
rtl/core/stmmx_seq.sv
rtl/core/segment_tree_min_max_xor.sv
verif/tb_top.sv
